>>> rtl/core/sha256_pkg.sv
// SHA-256 package: sequencer state type, round constants, initial hash values
// and the round and schedule mixing functions.
// No dependencies.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_DONE
  } state_t;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam logic [5:0] LAST_SLOT    = 6'd63;
  localparam logic [5:0] LAST_ROUND   = 6'd63;
  localparam logic [3:0] LEN_BYTES    = 4'd8;
  localparam logic [2:0] LAST_WORD_IX = 3'd7;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

>>> rtl/core/sha256_stream_if.sv
// Valid/ready channel interfaces for the SHA-256 hasher: message beats in,
// digest words out. No dependencies.
interface sha256_msg_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sha256_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> rtl/core/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream: block window, one-round-per-cycle compression
// sequencer, padding and digest output buffer.
// Depends on sha256_pkg and the channel interfaces in sha256_stream_if.sv.
//
//  channel  dir  payload                               beat meaning
//  msg      in   kind, data_byte                       one byte, or finish (kind=1)
//  digest   out  digest_word, word_index, last_word    one digest word, index 0 first
//
// A data beat shifts one byte into the block window; the beat that completes a
// 64-byte block also runs 64 rounds through the single round unit, then a fold.
// A finish beat pushes 9 to 72 padding bytes at one per cycle, runs one or two
// compressions, and loads the output buffer once it is free. The eight digest
// beats drain from that buffer while new bytes are taken.
// Synchronous reset; no clearing pass. A stalled digest holds only a new finish.
module sha256_byte_stream_hasher (
  input logic             clk,
  input logic             rst,
  sha256_msg_if.sink      msg,
  sha256_digest_if.source digest
);
  import sha256_pkg::*;

  state_t state, state_next;

  logic [31:0]  chain [8];
  logic [31:0]  v [8];
  logic [511:0] win;
  logic [5:0]   fill;
  logic [63:0]  total;
  logic [5:0]   rnd;
  logic         finishing;
  logic         sent_mark;
  logic [3:0]   len_cnt;
  logic [31:0]  out_words [8];
  logic         out_busy;
  logic [2:0]   out_idx;

  logic         msg_acc, out_acc;
  logic         push_en;
  logic [7:0]   push_byte;
  logic         len_push;
  logic [31:0]  w_t, w_new, t1, t2;

  assign msg_acc = msg.valid && msg.ready;
  assign out_acc = digest.valid && digest.ready;

  assign msg.ready          = (state == ST_IDLE);
  assign digest.valid       = out_busy;
  assign digest.digest_word = out_words[0];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == LAST_WORD_IX);

  // round unit and schedule; window word 0 (top) is W[t]
  assign w_t   = win[511:480];
  assign w_new = small1(win[63:32]) + win[223:192] + small0(win[479:448]) + w_t;
  assign t1    = v[7] + big1(v[4]) + choose(v[4], v[5], v[6]) + K[rnd] + w_t;
  assign t2    = big0(v[0]) + major(v[0], v[1], v[2]);

  always_comb begin
    state_next = state;
    push_en    = 1'b0;
    push_byte  = msg.data_byte;
    len_push   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (msg_acc) begin
          if (msg.kind) begin
            state_next = ST_PAD;
          end else begin
            push_en = 1'b1;
            if (fill == LAST_SLOT) state_next = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (!sent_mark) begin
          push_byte = PAD_MARK;
        end else if (len_cnt == 4'd0 && fill != LEN_POS) begin
          push_byte = 8'h00;
        end else begin
          push_byte = total[63:56];
          len_push  = 1'b1;
        end
        if (fill == LAST_SLOT) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd == LAST_ROUND) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (!finishing)              state_next = ST_IDLE;
        else if (len_cnt == LEN_BYTES) state_next = ST_DONE;
        else                         state_next = ST_PAD;
      end
      ST_DONE: begin
        if (!out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // payload datapath, no reset
  always_ff @(posedge clk) begin
    if (push_en) win <= {win[503:0], push_byte};
    if (push_en && fill == LAST_SLOT) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end
    if (state == ST_ROUND) begin
      win  <= {win[479:0], w_new};
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (state == ST_DONE && !out_busy) begin
      for (int i = 0; i < 8; i++) out_words[i] <= chain[i];
    end else if (out_acc) begin
      for (int i = 0; i < 7; i++) out_words[i] <= out_words[i+1];
    end
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
      fill      <= '0;
      total     <= '0;
      rnd       <= '0;
      finishing <= 1'b0;
      sent_mark <= 1'b0;
      len_cnt   <= '0;
      out_busy  <= 1'b0;
      out_idx   <= '0;
    end else begin
      if (push_en) fill <= fill + 6'd1;
      if (state == ST_IDLE && msg_acc) begin
        if (msg.kind) begin
          finishing <= 1'b1;
          total     <= {total[60:0], 3'b000};
        end else begin
          total <= total + 64'd1;
        end
      end
      if (state == ST_PAD) begin
        sent_mark <= 1'b1;
        if (len_push) begin
          total   <= {total[55:0], 8'h00};
          len_cnt <= len_cnt + 4'd1;
        end
      end
      if (state == ST_ROUND) rnd <= rnd + 6'd1;
      if (state == ST_FOLD) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
      end
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == LAST_WORD_IX) out_busy <= 1'b0;
      end
      if (state == ST_DONE && !out_busy) begin
        // hand digest to the output buffer and re-arm for the next message
        out_busy  <= 1'b1;
        out_idx   <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= IV[i];
        fill      <= '0;
        total     <= '0;
        finishing <= 1'b0;
        sent_mark <= 1'b0;
        len_cnt   <= '0;
      end
    end
  end

  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == LAST_ROUND) |=> (state == ST_FOLD))
    else $error("round count did not end in fold");

  a_pad_only_finishing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD) |-> (finishing && len_cnt != LEN_BYTES))
    else $error("padding outside a finish or past the length bytes");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_busy) |=> (out_busy && out_idx == 3'd0 && state == ST_IDLE))
    else $error("digest not loaded into output buffer");

  a_fold_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD) |-> (rnd == 6'd0))
    else $error("fold with round counter not wrapped");

endmodule

>>> dv/sha256_byte_stream_hasher_test.sv
// Self-checking testbench for sha256_byte_stream_hasher: streams messages byte by byte
// and checks every digest word against a SHA-256 model kept in a scoreboard class.
// Depends on the DUT and the msg/digest channel interfaces from the RTL.
module sha256_byte_stream_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_FINISH  = 1'b1;
  localparam int IDLE_PCT       = 37;
  localparam int HOLD_CYCLES    = 600;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_BEATS   = 410;
  localparam int HOLD_AT_BEAT   = 120;
  localparam int STEADY_FROM    = 220;
  localparam int STEADY_TO      = 320;

  localparam bit [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    bit [31:0] word;
    bit [2:0]  index;
    bit        is_last;
  } digest_beat_t;

  class digest_scoreboard;
    bit [31:0]    chain [8];
    bit [7:0]     blk [64];
    int unsigned  fill;
    bit [63:0]    byte_total;
    digest_beat_t pending [$];
    int           mismatches;
    int           words_seen;
    int           digests_seen;

    function new();
      rearm();
      mismatches = 0;
      words_seen = 0;
      digests_seen = 0;
    endfunction

    function void rearm();
      foreach (chain[i]) chain[i] = START_HASH[i];
      fill = 0;
      byte_total = 0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      for (int r = 0; r < 16; r++)
        w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      for (int r = 16; r < 64; r++) begin
        s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
        s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
        w[r] = w[r-16] + s0 + w[r-7] + s1;
      end
      v = chain;
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
        v[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] += v[i];
    endfunction

    function void absorb(bit [7:0] b);
      blk[fill] = b;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    // one accepted message beat; a finish pads, queues eight words and re-arms
    function void note_beat(logic kind, logic [7:0] data_byte);
      bit [63:0] bit_len;
      digest_beat_t exp;
      if (kind == KIND_DATA) begin
        absorb(data_byte);
        byte_total++;
      end else begin
        bit_len = byte_total << 3;
        absorb(8'h80);
        while (fill != 56) absorb(8'h00);
        for (int i = 0; i < 8; i++) absorb(bit_len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
          exp.word = chain[i];
          exp.index = i[2:0];
          exp.is_last = (i == 7);
          pending.push_back(exp);
        end
        rearm();
      end
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic is_last);
      digest_beat_t exp;
      words_seen++;
      if (is_last) digests_seen++;
      if (pending.size() == 0) begin
        $error("digest beat with none pending: digest_word %h word_index %0d", word, index);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      if (word !== exp.word) begin
        $error("digest_word: expected %h, actual %h", exp.word, word);
        mismatches++;
      end
      if (index !== exp.index) begin
        $error("word_index: expected %0d, actual %0d", exp.index, index);
        mismatches++;
      end
      if (is_last !== exp.is_last) begin
        $error("last_word: expected %0b, actual %0b", exp.is_last, is_last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sha256_msg_if    msg_ch ();
  sha256_digest_if dig_ch ();

  sha256_byte_stream_hasher DUT (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  digest_scoreboard sb = new();
  int  beats_sent = 0;
  bit  no_idle = 1'b0;
  bit  hold_request = 1'b0;

  task automatic send_beat(input logic kind, input logic [7:0] data_byte);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.kind      <= kind;
    msg_ch.data_byte <= data_byte;
    do @(posedge clk); while (!msg_ch.ready);
    sb.note_beat(kind, data_byte);
    beats_sent++;
    no_idle = (beats_sent >= STEADY_FROM) && (beats_sent < STEADY_TO);
    if (beats_sent == HOLD_AT_BEAT) hold_request = 1'b1;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_beat(KIND_DATA, 8'($urandom));
    send_beat(KIND_FINISH, 8'($urandom));
  endtask

  // lengths around the padding edges (55/56 bytes, block multiples) get extra weight
  function automatic int unsigned pick_length();
    int unsigned boundary_lens [12] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
    if ($urandom_range(9) < 4) return boundary_lens[$urandom_range(11)];
    return $urandom_range(90);
  endfunction

  // digest side: random back-pressure plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    dig_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && dig_ch.valid && dig_ch.ready)
        sb.check_word(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dig_ch.ready <= 1'b0;
      end else begin
        dig_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles, %0d digest words pending",
             STALL_LIMIT, sb.pending.size());
    $display("sha256_byte_stream_hasher: mismatch");
    $finish;
  end

  initial begin
    int start_beats;
    rst              <= 1'b1;
    msg_ch.valid     <= 1'b0;
    msg_ch.kind      <= KIND_DATA;
    msg_ch.data_byte <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message twice in a row, "abc", byte extremes
    send_beat(KIND_FINISH, 8'hff);
    send_beat(KIND_FINISH, 8'h00);
    send_beat(KIND_DATA, 8'h61);
    send_beat(KIND_DATA, 8'h62);
    send_beat(KIND_DATA, 8'h63);
    send_beat(KIND_FINISH, 8'h00);
    send_beat(KIND_DATA, 8'hff);
    send_beat(KIND_FINISH, 8'hff);
    send_beat(KIND_DATA, 8'h00);
    send_beat(KIND_FINISH, 8'h00);
    send_beat(KIND_DATA, 8'h80);
    send_beat(KIND_DATA, 8'h7f);
    send_beat(KIND_DATA, 8'h01);
    send_beat(KIND_FINISH, 8'h55);

    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) send_message(pick_length());
    msg_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d message beats; checked %0d digests (%0d words),",
             beats_sent, sb.digests_seen, sb.words_seen);
    $display("with lengths across the 55/56-byte padding edge and block multiples.");
    if (sb.mismatches == 0) begin
      $display("sha256_byte_stream_hasher: match");
    end else begin
      $display("sha256_byte_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule
